// ===== hdl/q2rm_pkg.sv =====
// Shared types and constants for the quaternion to rotation matrix core.
package q2rm_pkg;

    localparam int QBITS    = 16;   // quotient bits, one per divider cell
    localparam int NENT     = 9;    // matrix entries
    localparam int DEN_W    = 33;   // squared norm width
    localparam int REM_W    = 34;   // partial remainder width
    localparam int ENT_W    = 17;   // Q1.15 entry width, holds +1.0

    localparam logic signed [ENT_W-1:0] ONE_Q15 = 17'sd32768;

    // Payload that moves down the divider chain, nine lanes side by side.
    typedef struct packed {
        logic [NENT-1:0][REM_W-1:0] rem;
        logic [NENT-1:0][QBITS-1:0] quo;
        logic [NENT-1:0]            neg;
        logic [DEN_W-1:0]           den;
        logic                       zero;
    } div_t;

endpackage

// ===== hdl/quaternion_to_rotation_matrix_core.sv =====
// Top level of the quaternion to rotation matrix core.
//
//  Channel   Dir  Handshake               Content
//  s_axis    in   tvalid/tready           tdata: w, x, y, z (16 bits signed each)
//  m_axis    out  tvalid/tready           tdata: nine Q1.15 entries, tuser: zero_norm
//
// One item is accepted every cycle while the output side keeps up. The stages
// are the register of the ten 16x16 products, the norm and numerator register,
// the chain of divider cells (one quotient bit per cell), and sign restore in
// front of the output register. The divider chain sets the latency.
// Reset clears only the valid bits. When the output item is not taken, the
// whole pipeline holds, and the input side stalls in the same cycle.
module quaternion_to_rotation_matrix_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [63:0]    s_axis_tdata,   // comp_w, comp_x, comp_y, comp_z
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [159:0]   m_axis_tdata,   // m_r0c0 .. m_r2c2 (17 bits each), zeros
    output logic [0:0]     m_axis_tuser    // zero_norm
);
    import q2rm_pkg::*;

    logic adv;
    logic chain_valid [QBITS+1];
    div_t chain_data  [QBITS+1];

    logic                             out_valid_reg;
    logic [NENT-1:0][ENT_W-1:0]       ent_reg;
    logic [NENT-1:0][ENT_W-1:0]       ent_next;
    logic                             zero_reg;

    // The pipeline moves whenever the output register is empty or drained.
    assign adv = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    q2rm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .comp_w    (s_axis_tdata[15:0]),
        .comp_x    (s_axis_tdata[31:16]),
        .comp_y    (s_axis_tdata[47:32]),
        .comp_z    (s_axis_tdata[63:48]),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    // Each cell fixes one quotient bit, most significant first.
    for (genvar i = 0; i < QBITS; i++)
    begin : g_cell
        q2rm_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // Restore the sign; a zero quaternion yields the identity matrix.
    always_comb
    begin
        logic signed [ENT_W-1:0] q;
        for (int k = 0; k < NENT; k++)
        begin
            q = {1'b0, chain_data[QBITS].quo[k]};
            if (chain_data[QBITS].zero)
            begin
                ent_next[k] = (k % 4 == 0) ? ONE_Q15 : '0;
            end
            else
            begin
                ent_next[k] = chain_data[QBITS].neg[k] ? -q : q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= chain_valid[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ent_reg  <= ent_next;
            zero_reg <= chain_data[QBITS].zero;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, ent_reg};
    assign m_axis_tuser  = zero_reg;

`ifndef NO_ASSERTIONS
    // The input side is ready exactly when the output register can move.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output drain");

    // A zero quaternion is delivered with ones on the diagonal and zeros in entries 1 and 5.
    a_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        (ent_reg[0] == ONE_Q15 && ent_reg[4] == ONE_Q15 && ent_reg[8] == ONE_Q15
         && ent_reg[1] == '0 && ent_reg[5] == '0))
        else $error("zero quaternion did not give identity");

    // A stalled output register keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(ent_reg) && m_axis_tvalid))
        else $error("stalled result changed");
`endif

endmodule

// ===== hdl/q2rm_front.sv =====
// Product and numerator stages that feed the divider chain.
module q2rm_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic signed [15:0]    comp_w,
    input  logic signed [15:0]    comp_x,
    input  logic signed [15:0]    comp_y,
    input  logic signed [15:0]    comp_z,
    output logic                  out_valid,
    output q2rm_pkg::div_t        out_data
);
    import q2rm_pkg::*;

    logic                v1_reg;
    logic signed [31:0]  ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0]  xy_reg, zw_reg, xz_reg, yw_reg, yz_reg, xw_reg;
    logic                v2_reg;
    div_t                d2_reg;
    div_t                d2_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ww_reg <= comp_w * comp_w;
            xx_reg <= comp_x * comp_x;
            yy_reg <= comp_y * comp_y;
            zz_reg <= comp_z * comp_z;
            xy_reg <= comp_x * comp_y;
            zw_reg <= comp_z * comp_w;
            xz_reg <= comp_x * comp_z;
            yw_reg <= comp_y * comp_w;
            yz_reg <= comp_y * comp_z;
            xw_reg <= comp_x * comp_w;
            d2_reg <= d2_next;
        end
    end

    always_comb
    begin
        logic signed [REM_W-1:0] num [NENT];
        logic [DEN_W-1:0]        n2;
        logic [DEN_W-1:0]        mag;
        n2 = DEN_W'(ww_reg) + DEN_W'(xx_reg) + DEN_W'(yy_reg) + DEN_W'(zz_reg);
        num[0] = REM_W'(ww_reg) + REM_W'(xx_reg) - REM_W'(yy_reg) - REM_W'(zz_reg);
        num[1] = (REM_W'(xy_reg) + REM_W'(zw_reg)) <<< 1;
        num[2] = (REM_W'(xz_reg) - REM_W'(yw_reg)) <<< 1;
        num[3] = (REM_W'(xy_reg) - REM_W'(zw_reg)) <<< 1;
        num[4] = REM_W'(ww_reg) - REM_W'(xx_reg) + REM_W'(yy_reg) - REM_W'(zz_reg);
        num[5] = (REM_W'(yz_reg) + REM_W'(xw_reg)) <<< 1;
        num[6] = (REM_W'(xz_reg) + REM_W'(yw_reg)) <<< 1;
        num[7] = (REM_W'(yz_reg) - REM_W'(xw_reg)) <<< 1;
        num[8] = REM_W'(ww_reg) - REM_W'(xx_reg) - REM_W'(yy_reg) + REM_W'(zz_reg);
        d2_next.zero = (n2 == '0);
        // A zero norm divides by one; the result is replaced at the output.
        d2_next.den  = d2_next.zero ? DEN_W'(1) : n2;
        for (int k = 0; k < NENT; k++)
        begin
            mag = num[k][REM_W-1] ? DEN_W'(-num[k]) : DEN_W'(num[k]);
            d2_next.rem[k] = {1'b0, mag};
            d2_next.quo[k] = '0;
            d2_next.neg[k] = num[k][REM_W-1];
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = d2_reg;

endmodule

// ===== hdl/q2rm_cell.sv =====
// One restoring division cell: resolves one quotient bit in all nine lanes.
module q2rm_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  q2rm_pkg::div_t  in_data,
    output logic            out_valid,
    output q2rm_pkg::div_t  out_data
);
    import q2rm_pkg::*;

    logic valid_reg;
    div_t data_reg;
    div_t data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        logic             take;
        logic [REM_W-1:0] diff;
        data_next = in_data;
        for (int k = 0; k < NENT; k++)
        begin
            take = (in_data.rem[k] >= REM_W'(in_data.den));
            diff = take ? in_data.rem[k] - REM_W'(in_data.den) : in_data.rem[k];
            // The remainder stays below the divisor, so doubling fits.
            data_next.rem[k] = {diff[REM_W-2:0], 1'b0};
            data_next.quo[k] = {in_data.quo[k][QBITS-2:0], take};
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
